// ----- rtl/core/binary_max_heap_queue_defines.svh -----
// Assertion macros shared by the heap queue checker.
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// Concurrent assertion, held off while reset is asserted.
`define BMHQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("bmhq check failed");

// Concurrent assertion, checked during reset as well.
`define BMHQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bmhq check failed");

`endif

// ----- rtl/core/bmhq_pkg.sv -----
// Shared constants and types of the max heap queue.
`default_nettype none
package bmhq_pkg;
    localparam int CAPACITY_DEF    = 15;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;
endpackage
`default_nettype wire

// ----- rtl/core/bmhq_if.sv -----
// Valid/ready channel interfaces for the heap queue requests and results.
`default_nettype none
interface bmhq_in_if #(
    parameter int VW = 32
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic signed [VW-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface bmhq_out_if #(
    parameter int VW = 32,
    parameter int CW = 4
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic signed [VW-1:0] removed_value;
    logic signed [VW-1:0] top_value;
    logic [CW-1:0]        count;

    modport source (output valid, output status, output removed_value,
                    output top_value, output count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input top_value, input count, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bmhq_cell.sv -----
// One slot of the sorted value chain: holds a value and shifts with its neighbors.
`default_nettype none
module bmhq_cell
    import bmhq_pkg::*;
#(
    parameter int VW = VALUE_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic signed [VW-1:0] i_new_value,
    input  wire logic                 i_left_push,
    input  wire logic                 i_left_valid,
    input  wire logic signed [VW-1:0] i_left_value,
    input  wire logic                 i_right_valid,
    input  wire logic signed [VW-1:0] i_right_value,
    output logic                      o_valid,
    output logic signed [VW-1:0]      o_value,
    output logic                      o_push
);
    logic                 r_valid;
    logic                 n_valid;
    logic signed [VW-1:0] r_value;
    logic signed [VW-1:0] n_value;
    logic                 w_take;

    // New value lands here or nearer the head when it beats this slot.
    assign w_take = !r_valid || (i_new_value > r_value);
    assign o_push = r_valid && w_take;
    assign o_valid = r_valid;
    assign o_value = r_value;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.ins) begin
            n_valid = r_valid | i_left_valid;
            if (i_left_push) begin
                n_value = i_left_value;
            end else if (w_take) begin
                n_value = i_new_value;
            end
        end else if (i_ctl.rem) begin
            // advance everything one slot toward the head
            n_valid = i_right_valid;
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end
endmodule
`default_nettype wire

// ----- rtl/core/binary_max_heap_queue.sv -----
// Top level of the max priority queue built as a sorted chain of cells.
//
//  channel   dir  handshake            payload
//  i_item    in   valid / ready        mode, value
//  o_result  out  valid / ready        status, removed_value, top_value, count
//
// All cells compare against the new value and shift in parallel, so the chain takes
// one item a cycle whenever the output register is empty or being taken.
// The result appears in the cycle after acceptance, in an output register.
// i_item.ready is high while that register is empty or being taken.
// Synchronous active-low reset empties the chain and drops any pending result.
`default_nettype none
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bmhq_in_if.sink    i_item,
    bmhq_out_if.source o_result
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = VALUE_WIDTH;

    // Neighbor views with boundary slots at both ends.
    logic                 w_valid [0:CAPACITY+1];
    logic signed [VW-1:0] w_value [0:CAPACITY+1];
    logic                 w_push  [0:CAPACITY];

    t_cell_ctl            w_ctl;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_status              r_status;
    t_status              n_status;
    logic signed [VW-1:0] r_removed;
    logic signed [VW-1:0] n_removed;
    logic signed [VW-1:0] r_top;
    logic signed [VW-1:0] n_top;

    assign w_valid[0]          = 1'b1;
    assign w_value[0]          = '0;
    assign w_push[0]           = 1'b0;
    assign w_valid[CAPACITY+1] = 1'b0;
    assign w_value[CAPACITY+1] = '0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        bmhq_cell #(.VW(VW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_value  (i_item.value),
            .i_left_push  (w_push[k]),
            .i_left_valid (w_valid[k]),
            .i_left_value (w_value[k]),
            .i_right_valid(w_valid[k+2]),
            .i_right_value(w_value[k+2]),
            .o_valid      (w_valid[k+1]),
            .o_value      (w_value[k+1]),
            .o_push       (w_push[k+1])
        );
    end

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_full       = (r_count == CW'(CAPACITY));
    assign w_empty      = (r_count == '0);

    always_comb begin
        w_ctl.ins   = w_accept && (i_item.mode == MODE_INSERT) && !w_full;
        w_ctl.rem   = w_accept && (i_item.mode == MODE_REMOVE) && !w_empty;
        n_count     = r_count;
        n_status    = r_status;
        n_removed   = r_removed;
        n_top       = r_top;
        n_out_valid = r_out_valid && !o_result.ready;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_removed   = '0;
            if (i_item.mode == MODE_INSERT) begin
                if (w_full) begin
                    n_status = ST_FULL;
                    n_top    = w_value[1];
                end else begin
                    n_status = ST_DONE;
                    n_count  = r_count + 1'b1;
                    n_top    = (w_empty || (i_item.value > w_value[1])) ?
                               i_item.value : w_value[1];
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                    n_top    = '0;
                end else begin
                    n_status  = ST_DONE;
                    n_count   = r_count - 1'b1;
                    n_removed = w_value[1];
                    n_top     = w_valid[2] ? w_value[2] : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_removed <= n_removed;
        r_top     <= n_top;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_status;
    assign o_result.removed_value = r_removed;
    assign o_result.top_value     = r_top;
    assign o_result.count         = r_count;
endmodule
`default_nettype wire

// ----- rtl/core/bmhq_checker.sv -----
// Port-level checks of the heap queue, bound to the top level.
`default_nettype none
`include "binary_max_heap_queue_defines.svh"
module bmhq_checker
    import bmhq_pkg::*;
#(
    parameter int VW = VALUE_WIDTH_DEF,
    parameter int CW = 4
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [1:0]           i_status,
    input wire logic signed [VW-1:0] i_removed,
    input wire logic signed [VW-1:0] i_top,
    input wire logic [CW-1:0]        i_count
);
    `BMHQ_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid)

    `BMHQ_ASSERT(a_result_next_cycle, i_clk, i_rst_n,
        i_in_valid && i_in_ready |=> i_out_valid)

    `BMHQ_ASSERT(a_stall_holds, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) &&
        $stable(i_removed) && $stable(i_top) && $stable(i_count))

    `BMHQ_ASSERT(a_empty_reject_zero, i_clk, i_rst_n,
        i_out_valid && (i_status == ST_EMPTY) |->
        (i_count == '0) && (i_top == '0) && (i_removed == '0))

    // the removed root is the maximum, so nothing left can exceed it;
    // skip the case where the queue just emptied and the top reads zero
    `BMHQ_ASSERT(a_removed_is_max, i_clk, i_rst_n,
        i_out_valid && (i_removed != '0) && (i_count != '0) |-> (i_removed >= i_top))
endmodule

bind binary_max_heap_queue bmhq_checker #(
    .VW(VALUE_WIDTH),
    .CW($clog2(CAPACITY + 1))
) u_bmhq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_item.valid),
    .i_in_ready (i_item.ready),
    .i_out_valid(o_result.valid),
    .i_out_ready(o_result.ready),
    .i_status   (o_result.status),
    .i_removed  (o_result.removed_value),
    .i_top      (o_result.top_value),
    .i_count    (o_result.count)
);
`default_nettype wire

// ----- sim/heap_result_checker.sv -----
// Checker for the heap queue: tracks accepted items, predicts results and compares them.
`timescale 1ns / 1ps
module heap_result_checker
    import bmhq_pkg::*;
#(
    parameter int CAP = CAPACITY_DEF,
    parameter int VW  = VALUE_WIDTH_DEF,
    parameter int CW  = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bmhq_in_if        i_item,
    bmhq_out_if       i_result,
    output int        o_errors,
    output int        o_pending,
    output int        o_taken
);

    typedef struct packed {
        t_status              status;
        logic signed [VW-1:0] removed_value;
        logic signed [VW-1:0] top_value;
        logic [CW-1:0]        count;
    } t_heap_reply;

    logic signed [VW-1:0] heap_mem [CAP];
    int unsigned          heap_len;
    t_heap_reply          pending_replies [$];
    int                   mismatch_total;
    int                   taken_total;

    task automatic swap_entries(input int unsigned a, input int unsigned b);
        logic signed [VW-1:0] tmp;
        tmp         = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = tmp;
    endtask

    // Apply one item to the shadow heap and return the result it should produce.
    task automatic heap_apply(input logic mode, input logic signed [VW-1:0] value,
                              output t_heap_reply reply);
        int unsigned idx;
        int unsigned parent;
        int unsigned left;
        int unsigned pick;
        bit          moving;
        reply        = '0;
        reply.status = ST_DONE;
        if (mode == MODE_INSERT) begin
            if (heap_len >= CAP) begin
                reply.status = ST_FULL;
            end else begin
                heap_mem[heap_len] = value;
                idx = heap_len;
                heap_len++;
                moving = 1'b1;
                while (moving && idx > 0) begin
                    parent = (idx - 1) / 2;
                    if (heap_mem[idx] > heap_mem[parent]) begin
                        swap_entries(idx, parent);
                        idx = parent;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end else begin
            if (heap_len == 0) begin
                reply.status = ST_EMPTY;
            end else begin
                reply.removed_value = heap_mem[0];
                heap_mem[0] = heap_mem[heap_len - 1];
                heap_len--;
                idx = 0;
                moving = 1'b1;
                while (moving) begin
                    left = 2 * idx + 1;
                    if (left >= heap_len) begin
                        moving = 1'b0;
                    end else begin
                        // left child wins ties
                        pick = left;
                        if (left + 1 < heap_len && heap_mem[left + 1] > heap_mem[left])
                            pick = left + 1;
                        if (heap_mem[pick] > heap_mem[idx]) begin
                            swap_entries(idx, pick);
                            idx = pick;
                        end else begin
                            moving = 1'b0;
                        end
                    end
                end
            end
        end
        reply.top_value = (heap_len > 0) ? heap_mem[0] : '0;
        reply.count     = heap_len[CW-1:0];
    endtask

    always @(posedge i_clk) begin : watch
        t_heap_reply want;
        if (!i_rst_n) begin
            heap_len = 0;
            pending_replies.delete();
            mismatch_total = 0;
            taken_total    = 0;
        end else begin
            // take the input first so a same-edge result still finds its expectation
            if (i_item.valid && i_item.ready) begin
                heap_apply(i_item.mode, i_item.value, want);
                pending_replies.push_back(want);
            end
            if (i_result.valid && i_result.ready) begin
                taken_total++;
                if (pending_replies.size() == 0) begin
                    $error("result with no pending item: status %0d top %0d count %0d",
                           i_result.status, i_result.top_value, i_result.count);
                    mismatch_total++;
                end else begin
                    want = pending_replies.pop_front();
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status,
                               i_result.status);
                        mismatch_total++;
                    end
                    if (i_result.removed_value !== want.removed_value) begin
                        $error("removed_value: expected %0d, actual %0d",
                               want.removed_value, i_result.removed_value);
                        mismatch_total++;
                    end
                    if (i_result.top_value !== want.top_value) begin
                        $error("top_value: expected %0d, actual %0d", want.top_value,
                               i_result.top_value);
                        mismatch_total++;
                    end
                    if (i_result.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count,
                               i_result.count);
                        mismatch_total++;
                    end
                end
            end
        end
        o_errors  <= mismatch_total;
        o_pending <= pending_replies.size();
        o_taken   <= taken_total;
    end

endmodule

// ----- sim/tb_binary_max_heap_queue.sv -----
// Testbench top for the heap queue: clock, reset, item and result traffic, verdict.
`timescale 1ns / 1ps
module tb_binary_max_heap_queue;
    import bmhq_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int VW           = VALUE_WIDTH_DEF;
    localparam int CW           = 4;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 400;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    logic i_clk;
    logic i_rst_n;
    int   error_count;
    int   pending_count;
    int   taken_count;
    int   cycle_count;
    bit   send_calm;

    bmhq_in_if  #(.VW(VW))          item_ch ();
    bmhq_out_if #(.VW(VW), .CW(CW)) result_ch ();

    binary_max_heap_queue #(
        .CAPACITY   (CAP),
        .VALUE_WIDTH(VW)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_result(result_ch.source)
    );

    heap_result_checker #(
        .CAP(CAP),
        .VW (VW),
        .CW (CW)
    ) checker_inst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_result (result_ch),
        .o_errors (error_count),
        .o_pending(pending_count),
        .o_taken  (taken_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Offer one item from a falling edge and hold it until accepted.
    task automatic push_item(input logic mode, input logic signed [VW-1:0] value);
        int gap;
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid = 1'b1;
        item_ch.mode  = mode;
        item_ch.value = value;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic signed [VW-1:0] pick_value(input logic signed [VW-1:0] last);
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(0, 8)) - 4;
            7:          return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            8:          return $urandom_range(0, 1) ? VAL_MAX - $urandom_range(0, 3)
                                                    : VAL_MIN + $urandom_range(0, 3);
            default:    return last;
        endcase
    endfunction

    // Watchdog: end the run if the traffic never drains.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_binary_max_heap_queue: done, errors");
        $finish;
    end

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial begin : drain_ctl
        int  hold_left;
        int  calm_left;
        bit  long_done;
        result_ch.ready = 1'b0;
        hold_left = 0;
        calm_left = 0;
        long_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_done && taken_count >= HOLD_AFTER) begin
                long_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (calm_left == 0 && $urandom_range(0, 199) == 0)
                calm_left = $urandom_range(50, 150);
            if (hold_left > 0) begin
                result_ch.ready = 1'b0;
                hold_left--;
            end else if (calm_left > 0) begin
                result_ch.ready = 1'b1;
                calm_left--;
            end else if ($urandom_range(0, 99) < 30) begin
                result_ch.ready = 1'b0;
                hold_left = pick_gap();
            end else begin
                result_ch.ready = 1'b1;
            end
        end
    end

    initial begin : item_ctl
        int                   n;
        int                   ins_pct;
        logic                 mode;
        logic signed [VW-1:0] last_val;
        logic signed [VW-1:0] value;
        i_rst_n       = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.mode  = MODE_INSERT;
        item_ch.value = '0;
        send_calm     = 1'b0;
        last_val      = '0;
        ins_pct       = 50;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // removal from empty, then a single insert removed again
        push_item(MODE_REMOVE, VAL_MAX);
        push_item(MODE_INSERT, VAL_MAX);
        push_item(MODE_REMOVE, '0);
        // fill to capacity with extremes and ties
        push_item(MODE_INSERT, VAL_MIN);
        push_item(MODE_INSERT, VAL_MAX);
        push_item(MODE_INSERT, '0);
        push_item(MODE_INSERT, -1);
        push_item(MODE_INSERT, 5);
        push_item(MODE_INSERT, 5);
        push_item(MODE_INSERT, 5);
        push_item(MODE_INSERT, VAL_MIN);
        push_item(MODE_INSERT, VAL_MAX);
        push_item(MODE_INSERT, 1);
        push_item(MODE_INSERT, -2);
        push_item(MODE_INSERT, 32'sh5555_5555);
        push_item(MODE_INSERT, 32'shAAAA_AAAA);
        push_item(MODE_INSERT, 100);
        push_item(MODE_INSERT, 100);
        // insert into a full heap
        push_item(MODE_INSERT, VAL_MAX);
        repeat (5) push_item(MODE_REMOVE, '1);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // switch bias every 40 items so the fill level sweeps from empty to full
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       ins_pct = 85;
                    1:       ins_pct = 20;
                    default: ins_pct = 50;
                endcase
                send_calm = ($urandom_range(0, 3) == 0);
            end
            mode  = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
            value = pick_value(last_val);
            if (mode == MODE_INSERT)
                last_val = value;
            push_item(mode, value);
        end
        item_ch.valid = 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0)
            $display("tb_binary_max_heap_queue: done, clean");
        else
            $display("tb_binary_max_heap_queue: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_if.sv
rtl/core/bmhq_cell.sv
rtl/core/binary_max_heap_queue.sv
rtl/core/bmhq_checker.sv
sim/heap_result_checker.sv
sim/tb_binary_max_heap_queue.sv
